/* src/clhx_pkg.sv */
// Package for the card identifier line to hex converter.
// Holds widths, ASCII codes, command and state types and the shared helper functions.
// Used by every module of the block but clhx_ram; depends on nothing.
package clhx_pkg;

   // Default line length in raw characters.
   localparam int LINE_CHARS_DEF = 32;

   // Digit store geometry.
   localparam int KEPT_DEPTH = 32;
   localparam int KEPT_AW    = $clog2(KEPT_DEPTH);
   localparam int NIB_W      = 4;

   // Decimal value and its hex digits.
   localparam int VALUE_W   = 64;
   localparam int DIGITS    = VALUE_W / NIB_W;
   localparam int DIG_IDX_W = $clog2(DIGITS);

   // Timeout and elapsed tick counter.
   localparam int                 TIMEOUT_W     = 16;
   localparam int                 ELAPSED_W     = TIMEOUT_W + 1;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd100;

   // Configuration port.
   localparam int CSR_ADDR_W       = 2;
   localparam int CSR_DATA_W       = 32;
   localparam int REG_LINE_TIMEOUT = 0;

   // Payload widths.
   localparam int BYTE_W = 8;
   localparam int CHAR_W = 7;

   // Command queue between front and back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // Input opcodes.
   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // ASCII codes.
   localparam logic [BYTE_W-1:0] ASCII_LF = 8'h0A;
   localparam logic [BYTE_W-1:0] ASCII_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] ASCII_0  = 8'h30;
   localparam logic [BYTE_W-1:0] ASCII_9  = 8'h39;
   localparam logic [BYTE_W-1:0] ASCII_UA = 8'h41;
   localparam logic [BYTE_W-1:0] ASCII_UF = 8'h46;
   localparam logic [BYTE_W-1:0] ASCII_LA = 8'h61;
   localparam logic [BYTE_W-1:0] ASCII_LF_CHAR = 8'h66;

   // Kinds of command the front hands to the back.
   typedef enum logic [1:0] {
      CMD_CHAR,
      CMD_EOL,
      CMD_TICK
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type           kind;
      logic [NIB_W-1:0]       nib;
      logic                   is_hex;
      logic                   is_dec;
   } cmd_type;

   // Back end sequencer states.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ADD,
      ST_DEC,
      ST_HEX_WAIT,
      ST_HEX_OUT
   } back_state_type;

   // Classifies one input item into a command.
   function automatic cmd_type classify_item(input logic opcode, input logic [BYTE_W-1:0] rx);
      cmd_type c;
      c.kind   = CMD_CHAR;
      c.nib    = '0;
      c.is_hex = 1'b0;
      c.is_dec = 1'b0;
      if (opcode == OP_TICK) begin
         c.kind = CMD_TICK;
      end else if (rx == ASCII_LF || rx == ASCII_CR) begin
         c.kind = CMD_EOL;
      end else if (rx >= ASCII_0 && rx <= ASCII_9) begin
         c.is_hex = 1'b1;
         c.is_dec = 1'b1;
         c.nib    = NIB_W'(rx - ASCII_0);
      end else if (rx >= ASCII_LA && rx <= ASCII_LF_CHAR) begin
         c.is_hex = 1'b1;
         c.nib    = NIB_W'(rx - ASCII_LA + 8'd10);
      end else if (rx >= ASCII_UA && rx <= ASCII_UF) begin
         c.is_hex = 1'b1;
         c.nib    = NIB_W'(rx - ASCII_UA + 8'd10);
      end
      return c;
   endfunction

   // Turns a nibble into its uppercase ASCII hex character.
   function automatic logic [CHAR_W-1:0] nibble_char(input logic [NIB_W-1:0] n);
      logic [CHAR_W-1:0] r;
      if (n < 4'd10) begin
         r = CHAR_W'(ASCII_0) + CHAR_W'(n);
      end else begin
         r = CHAR_W'(ASCII_UA) + CHAR_W'(n - 4'd10);
      end
      return r;
   endfunction

endpackage

/* src/clhx_ram.sv */
// Generic single write port, single read port RAM with registered read data.
// Holds the kept hex digits of a line; depends on nothing.
module clhx_ram #(
   parameter int WIDTH = 4,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/clhx_front.sv */
// Front end: accepts input items, classifies them and queues the commands.
// Depends on clhx_pkg for the command type and the classifier.
module clhx_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_opcode,
   input  logic [clhx_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              cmd_valid,
   input  logic                              cmd_ready,
   output clhx_pkg::cmd_type                 cmd
);

   clhx_pkg::cmd_type               queue_ff [clhx_pkg::QUEUE_DEPTH];
   logic [clhx_pkg::QUEUE_PW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [clhx_pkg::QUEUE_PW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [clhx_pkg::QUEUE_CW-1:0]   count_ff, count_in;
   logic                            push;
   logic                            pop;

   // Handshakes on both sides of the queue.
   assign req_ready = (count_ff != clhx_pkg::QUEUE_CW'(clhx_pkg::QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = queue_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == clhx_pkg::QUEUE_PW'(clhx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == clhx_pkg::QUEUE_PW'(clhx_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Classified item goes into the queue entry.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= clhx_pkg::classify_item(req_opcode, req_rx_byte);
      end
   end

endmodule

/* src/clhx_back.sv */
// Back end: keeps the line state, runs the timeout and emits the identifier.
// Depends on clhx_pkg and instantiates clhx_ram for the kept digits.
module clhx_back #(
   parameter int LINE_CHARS = clhx_pkg::LINE_CHARS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               cmd_valid,
   output logic                               cmd_ready,
   input  clhx_pkg::cmd_type                  cmd,
   input  logic [clhx_pkg::TIMEOUT_W-1:0]     line_timeout,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [clhx_pkg::CHAR_W-1:0]        rsp_hex_char,
   output logic                               rsp_last_char
);

   localparam int LINE_CW = $clog2(LINE_CHARS + 1);
   localparam int CNT_W   = (LINE_CW > clhx_pkg::KEPT_AW + 1) ? LINE_CW : clhx_pkg::KEPT_AW + 1;
   localparam int VW      = clhx_pkg::VALUE_W;
   localparam int NW      = clhx_pkg::NIB_W;
   localparam int AW      = clhx_pkg::KEPT_AW;
   localparam int EW      = clhx_pkg::ELAPSED_W;

   clhx_pkg::back_state_type          state_ff, state_in;
   logic [CNT_W-1:0]                  raw_ff, raw_in;
   logic [CNT_W-1:0]                  kept_ff, kept_in;
   logic [VW-1:0]                     value_ff, value_in;
   logic                              all_dec_ff, all_dec_in;
   logic                              open_ff, open_in;
   logic [EW-1:0]                     elapsed_ff, elapsed_in;
   logic [NW-1:0]                     digit_ff, digit_in;
   logic [VW-1:0]                     shift_ff, shift_in;
   logic [clhx_pkg::DIG_IDX_W-1:0]    dig_idx_ff, dig_idx_in;
   logic                              started_ff, started_in;
   logic [AW-1:0]                     emit_idx_ff, emit_idx_in;
   logic [AW-1:0]                     emit_last_ff, emit_last_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [clhx_pkg::CHAR_W-1:0]       rsp_char_ff, rsp_char_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic                              out_free;
   logic                              finish;
   logic                              clear;
   logic [EW-1:0]                     elapsed_inc;
   logic [NW-1:0]                     top_nib;
   logic                              ram_we;
   logic [NW-1:0]                     ram_rdata;

   // Kept digit store, read back in order for a non-decimal identifier.
   clhx_ram #(
      .WIDTH (NW),
      .DEPTH (clhx_pkg::KEPT_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (kept_ff[AW-1:0]),
      .wr_data (cmd.nib),
      .rd_addr (emit_idx_ff),
      .rd_data (ram_rdata)
   );

   // Saturating tick count and the leading digit of the value being emitted.
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + 1'b1;
   assign top_nib     = shift_ff[VW-1 -: NW];
   assign out_free    = !rsp_valid_ff || rsp_ready;

   // Next state and line state updates.
   always_comb begin
      state_in     = state_ff;
      raw_in       = raw_ff;
      kept_in      = kept_ff;
      value_in     = value_ff;
      all_dec_in   = all_dec_ff;
      open_in      = open_ff;
      elapsed_in   = elapsed_ff;
      digit_in     = digit_ff;
      shift_in     = shift_ff;
      dig_idx_in   = dig_idx_ff;
      started_in   = started_ff;
      emit_idx_in  = emit_idx_ff;
      emit_last_in = emit_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      cmd_ready    = 1'b0;
      ram_we       = 1'b0;
      finish       = 1'b0;
      clear        = 1'b0;

      unique case (state_ff)
         clhx_pkg::ST_IDLE: begin
            if (cmd_valid) begin
               cmd_ready = 1'b1;
               unique case (cmd.kind)
                  clhx_pkg::CMD_TICK: begin
                     if (open_ff) begin
                        elapsed_in = elapsed_inc;
                        if (raw_ff != '0 && elapsed_inc > {1'b0, line_timeout}) begin
                           finish = 1'b1;
                        end
                     end
                  end
                  clhx_pkg::CMD_EOL: begin
                     if (raw_ff != '0) begin
                        finish = 1'b1;
                     end else begin
                        clear = 1'b1;
                     end
                  end
                  clhx_pkg::CMD_CHAR: begin
                     // The first character of a line opens it and restarts the timeout.
                     if (raw_ff == '0) begin
                        elapsed_in = '0;
                        open_in    = 1'b1;
                     end
                     if (raw_ff < CNT_W'(LINE_CHARS)) begin
                        raw_in = raw_ff + 1'b1;
                        if (cmd.is_hex) begin
                           ram_we  = (kept_ff < CNT_W'(clhx_pkg::KEPT_DEPTH));
                           kept_in = kept_ff + 1'b1;
                        end
                        // Times ten now, the digit is added in the next cycle.
                        if (cmd.is_dec) begin
                           value_in = (value_ff << 3) + (value_ff << 1);
                           digit_in = cmd.nib;
                           state_in = clhx_pkg::ST_ADD;
                        end else if (cmd.is_hex) begin
                           all_dec_in = 1'b0;
                        end
                     end
                  end
                  default: begin
                     clear = 1'b0;
                  end
               endcase
            end
         end

         clhx_pkg::ST_ADD: begin
            value_in = value_ff + VW'(digit_ff);
            state_in = clhx_pkg::ST_IDLE;
         end

         clhx_pkg::ST_DEC: begin
            // Leading zeros are skipped, but the last digit always goes out.
            if (!started_ff && top_nib == '0 && dig_idx_ff != '0) begin
               shift_in   = shift_ff << NW;
               dig_idx_in = dig_idx_ff - 1'b1;
            end else if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = clhx_pkg::nibble_char(top_nib);
               rsp_last_in  = (dig_idx_ff == '0);
               started_in   = 1'b1;
               if (dig_idx_ff == '0) begin
                  state_in = clhx_pkg::ST_IDLE;
               end else begin
                  shift_in   = shift_ff << NW;
                  dig_idx_in = dig_idx_ff - 1'b1;
               end
            end
         end

         clhx_pkg::ST_HEX_WAIT: begin
            state_in = clhx_pkg::ST_HEX_OUT;
         end

         clhx_pkg::ST_HEX_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = clhx_pkg::nibble_char(ram_rdata);
               rsp_last_in  = (emit_idx_ff == emit_last_ff);
               if (emit_idx_ff == emit_last_ff) begin
                  state_in = clhx_pkg::ST_IDLE;
               end else begin
                  emit_idx_in = emit_idx_ff + 1'b1;
                  state_in    = clhx_pkg::ST_HEX_WAIT;
               end
            end
         end

         default: begin
            state_in = clhx_pkg::ST_IDLE;
         end
      endcase

      // End of line: start emission from a snapshot if a digit was kept, then clear the line.
      if (finish) begin
         if (kept_ff != '0) begin
            if (all_dec_ff) begin
               shift_in   = value_ff;
               dig_idx_in = clhx_pkg::DIG_IDX_W'(clhx_pkg::DIGITS - 1);
               started_in = 1'b0;
               state_in   = clhx_pkg::ST_DEC;
            end else begin
               emit_idx_in  = '0;
               emit_last_in = (kept_ff >= CNT_W'(clhx_pkg::KEPT_DEPTH)) ?
                              AW'(clhx_pkg::KEPT_DEPTH - 1) : AW'(kept_ff - CNT_W'(1));
               state_in     = clhx_pkg::ST_HEX_WAIT;
            end
         end
         clear = 1'b1;
      end

      if (clear) begin
         raw_in     = '0;
         kept_in    = '0;
         value_in   = '0;
         all_dec_in = 1'b1;
         open_in    = 1'b0;
         elapsed_in = '0;
      end
   end

   // Control and line state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clhx_pkg::ST_IDLE;
         raw_ff       <= '0;
         kept_ff      <= '0;
         value_ff     <= '0;
         all_dec_ff   <= 1'b1;
         open_ff      <= 1'b0;
         elapsed_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         raw_ff       <= raw_in;
         kept_ff      <= kept_in;
         value_ff     <= value_in;
         all_dec_ff   <= all_dec_in;
         open_ff      <= open_in;
         elapsed_ff   <= elapsed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Emission payload registers.
   always_ff @(posedge clock) begin
      digit_ff     <= digit_in;
      shift_ff     <= shift_in;
      dig_idx_ff   <= dig_idx_in;
      started_ff   <= started_in;
      emit_idx_ff  <= emit_idx_in;
      emit_last_ff <= emit_last_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_hex_char  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

endmodule

/* src/card_id_line_to_hex.sv */
// Top level of the card identifier line to hex converter.
// Depends on clhx_pkg; instantiates clhx_front and clhx_back and holds the timeout register.
//
// Bytes from a card reader and millisecond ticks enter on the req_ channel; a line ends on
// CR or LF, or on a tick once more than line_timeout_ticks ticks have passed since its first
// character, and the card identifier then leaves on the rsp_ channel as uppercase ASCII hex,
// one character per item, the final one marked by rsp_last_char. Items pass a two-entry
// command queue; the back end takes one command per cycle while idle, a decimal digit also
// holding it in the add state, as the times-ten step and the digit add are split over the
// value register. An all-decimal identifier leaves at one character per cycle unless
// stalled, once its leading zeros are skipped; any other alternates wait and output states
// per character, the digit store read being registered. While an identifier is being sent,
// new items wait in the queue. The timeout register is at byte address 0 and resets to 100.
module card_id_line_to_hex #(
   parameter int LINE_CHARS = clhx_pkg::LINE_CHARS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_opcode,
   input  logic [clhx_pkg::BYTE_W-1:0]         req_rx_byte,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [clhx_pkg::CHAR_W-1:0]         rsp_hex_char,
   output logic                                rsp_last_char,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [clhx_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [clhx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [clhx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [clhx_pkg::TIMEOUT_W-1:0]   timeout_ff, timeout_in;
   logic [clhx_pkg::CSR_ADDR_W-1:0]  csr_word;
   logic                             csr_sel;
   logic                             cmd_valid;
   logic                             cmd_ready;
   clhx_pkg::cmd_type                cmd;

   // Register decode: byte offset dropped, word index picks the register.
   assign csr_pready = 1'b1;
   assign csr_word   = csr_paddr >> 2;
   assign csr_sel    = (csr_word == clhx_pkg::CSR_ADDR_W'(clhx_pkg::REG_LINE_TIMEOUT));
   assign csr_prdata = csr_sel ? clhx_pkg::CSR_DATA_W'(timeout_ff) : '0;

   always_comb begin
      timeout_in = timeout_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_sel) begin
         timeout_in = csr_pwdata[clhx_pkg::TIMEOUT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= clhx_pkg::TIMEOUT_RESET;
      end else begin
         timeout_ff <= timeout_in;
      end
   end

   // Front end: classification and command queue.
   clhx_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_opcode  (req_opcode),
      .req_rx_byte (req_rx_byte),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd)
   );

   // Back end: line state, timeout and emission.
   clhx_back #(
      .LINE_CHARS (LINE_CHARS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (cmd_valid),
      .cmd_ready     (cmd_ready),
      .cmd           (cmd),
      .line_timeout  (timeout_ff),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hex_char  (rsp_hex_char),
      .rsp_last_char (rsp_last_char)
   );

endmodule

/* src/clhx_checker.sv */
// Port-level checks for the card identifier line to hex converter.
// Depends on clhx_pkg; bound to card_id_line_to_hex at the end of this file.
module clhx_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [clhx_pkg::CHAR_W-1:0]         rsp_hex_char,
   input logic                                rsp_last_char,
   input logic                                csr_psel,
   input logic                                csr_penable,
   input logic                                csr_pwrite,
   input logic [clhx_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   input logic [clhx_pkg::CSR_DATA_W-1:0]     csr_prdata,
   input logic                                csr_pready
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hex_char) && $stable(rsp_last_char))
      else $error("result item changed while stalled");

   // Every result item is an uppercase hex digit.
   a_rsp_hex: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         (rsp_hex_char >= clhx_pkg::CHAR_W'(clhx_pkg::ASCII_0) &&
          rsp_hex_char <= clhx_pkg::CHAR_W'(clhx_pkg::ASCII_9)) ||
         (rsp_hex_char >= clhx_pkg::CHAR_W'(clhx_pkg::ASCII_UA) &&
          rsp_hex_char <= clhx_pkg::CHAR_W'(clhx_pkg::ASCII_UF)))
      else $error("result item is not an uppercase hex digit");

   // Reset leaves no result pending and an empty queue that takes items.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("block not idle after reset");

   // A written timeout reads back at once.
   a_csr_readback: assert property (@(posedge clock) disable iff (reset)
      csr_psel && csr_penable && csr_pwrite && csr_pready |=>
         csr_prdata == clhx_pkg::CSR_DATA_W'($past(csr_pwdata[clhx_pkg::TIMEOUT_W-1:0])))
      else $error("timeout register does not read back the written value");

endmodule

bind card_id_line_to_hex clhx_checker u_clhx_checker (.*);

/* sim/tb_card_id_line_to_hex.sv */
// Self-checking testbench for card_id_line_to_hex.
// Depends on clhx_pkg and the RTL of card_id_line_to_hex; holds its own line predictor
// and checks every identifier character the block sends against it.
`timescale 1ns / 1ps

module tb_card_id_line_to_hex;

   localparam int CLK_HALF     = 2;
   localparam int LINE_LEN     = clhx_pkg::LINE_CHARS_DEF;
   localparam int TICKS_SAT    = 131071;
   localparam int SETTLE_CYC   = 24;
   localparam int QUIET_LIMIT  = 5000;
   localparam int HOLD_CYC     = 400;
   localparam int PHASE_ITEMS  = 50;
   localparam logic [clhx_pkg::CSR_ADDR_W-1:0] TIMEOUT_ADDR =
      clhx_pkg::CSR_ADDR_W'(4 * clhx_pkg::REG_LINE_TIMEOUT);

   typedef struct {
      logic [clhx_pkg::CHAR_W-1:0] ch;
      logic                        is_last;
   } id_char_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_ready;
   logic                              req_opcode = clhx_pkg::OP_BYTE;
   logic [clhx_pkg::BYTE_W-1:0]       req_rx_byte = '0;
   logic                              rsp_valid;
   logic                              rsp_ready = 1'b0;
   logic [clhx_pkg::CHAR_W-1:0]       rsp_hex_char;
   logic                              rsp_last_char;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [clhx_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [clhx_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [clhx_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // Predictor state of the line being collected.
   logic [clhx_pkg::TIMEOUT_W-1:0]    line_timeout_q = clhx_pkg::TIMEOUT_RESET;
   int                                line_raw_n = 0;
   logic [clhx_pkg::NIB_W-1:0]        digit_store [clhx_pkg::KEPT_DEPTH];
   int                                digit_n = 0;
   logic [clhx_pkg::VALUE_W-1:0]      dec_acc = '0;
   bit                                only_dec = 1'b1;
   bit                                line_busy = 1'b0;
   int                                ticks_since = 0;

   // Identifier characters still due from the block.
   id_char_type                       id_chars_q[$];

   int                                err_count = 0;
   int                                items_sent = 0;
   int                                chars_checked = 0;
   int                                ids_checked = 0;
   int                                idle_pct = 0;
   int                                stall_pct = 0;
   int                                hold_ask = 0;
   int                                hold_left = 0;
   int                                quiet_cycles = 0;

   card_id_line_to_hex u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_hex_char  (rsp_hex_char),
      .rsp_last_char (rsp_last_char),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor.
   // ------------------------------------------------------------------

   function automatic logic [clhx_pkg::CHAR_W-1:0] hex_ascii(
      input logic [clhx_pkg::NIB_W-1:0] n);
      if (n < 4'd10) begin
         return clhx_pkg::CHAR_W'(clhx_pkg::ASCII_0) + clhx_pkg::CHAR_W'(n);
      end
      return clhx_pkg::CHAR_W'(clhx_pkg::ASCII_UA) + clhx_pkg::CHAR_W'(n - 4'd10);
   endfunction

   task automatic clear_line_state();
      line_raw_n  = 0;
      digit_n     = 0;
      dec_acc     = '0;
      only_dec    = 1'b1;
      line_busy   = 1'b0;
      ticks_since = 0;
   endtask

   // Queues the identifier of the current line, then starts a fresh line.
   task automatic emit_identifier();
      int top;
      int n;
      if (digit_n > 0) begin
         if (only_dec) begin
            // Value in hex with leading zeros skipped, a single zero kept.
            top = clhx_pkg::DIGITS - 1;
            while (top > 0 && dec_acc[4*top +: 4] == 4'd0) top--;
            for (int i = top; i >= 0; i--) begin
               id_chars_q.push_back('{hex_ascii(dec_acc[4*i +: 4]), i == 0});
            end
         end else begin
            n = (digit_n < clhx_pkg::KEPT_DEPTH) ? digit_n : clhx_pkg::KEPT_DEPTH;
            for (int i = 0; i < n; i++) begin
               id_chars_q.push_back('{hex_ascii(digit_store[i]), i + 1 == n});
            end
         end
      end
      clear_line_state();
   endtask

   // Advances the predictor by one accepted item.
   task automatic predict_card_item(input logic op, input logic [clhx_pkg::BYTE_W-1:0] b);
      int nib;
      nib = -1;
      if (op == clhx_pkg::OP_TICK) begin
         if (line_busy) begin
            if (ticks_since < TICKS_SAT) ticks_since++;
            if (line_raw_n > 0 && ticks_since > int'(line_timeout_q)) emit_identifier();
         end
      end else if (b == clhx_pkg::ASCII_LF || b == clhx_pkg::ASCII_CR) begin
         if (line_raw_n > 0) begin
            emit_identifier();
         end else begin
            clear_line_state();
         end
      end else begin
         if (line_raw_n == 0) begin
            ticks_since = 0;
            line_busy   = 1'b1;
         end
         // Characters past the line length are dropped without effect.
         if (line_raw_n < LINE_LEN) begin
            line_raw_n++;
            if (b >= clhx_pkg::ASCII_0 && b <= clhx_pkg::ASCII_9) begin
               nib     = int'(b - clhx_pkg::ASCII_0);
               dec_acc = dec_acc * 64'd10 + clhx_pkg::VALUE_W'(nib);
            end else if (b >= clhx_pkg::ASCII_LA && b <= clhx_pkg::ASCII_LF_CHAR) begin
               nib      = int'(b - clhx_pkg::ASCII_LA) + 10;
               only_dec = 1'b0;
            end else if (b >= clhx_pkg::ASCII_UA && b <= clhx_pkg::ASCII_UF) begin
               nib      = int'(b - clhx_pkg::ASCII_UA) + 10;
               only_dec = 1'b0;
            end
            if (nib >= 0) begin
               if (digit_n < clhx_pkg::KEPT_DEPTH) begin
                  digit_store[digit_n] = clhx_pkg::NIB_W'(nib);
               end
               digit_n++;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Result checking, receiver stalls and the watchdog.
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      id_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (id_chars_q.size() == 0) begin
            $error("unexpected item: hex_char %h last_char %b", rsp_hex_char, rsp_last_char);
            err_count++;
         end else begin
            want = id_chars_q.pop_front();
            chars_checked++;
            if (want.is_last) ids_checked++;
            if (rsp_hex_char !== want.ch) begin
               $error("hex_char: expected %h, got %h", want.ch, rsp_hex_char);
               err_count++;
            end
            if (rsp_last_char !== want.is_last) begin
               $error("last_char: expected %b, got %b", want.is_last, rsp_last_char);
               err_count++;
            end
         end
      end
   end

   // The receiver stalls at random, or holds off for a counted stretch on request.
   always @(posedge clock) begin
      if (hold_ask > 0) begin
         hold_left = hold_ask;
         hold_ask  = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (reset || csr_psel || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Timeout: no item moved for %0d cycles", QUIET_LIMIT);
         $display("** card_id_line_to_hex: FAILED **");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Drivers.
   // ------------------------------------------------------------------

   // Offers one item, after a random gap, and predicts it once accepted.
   task automatic send_item(input logic op, input logic [clhx_pkg::BYTE_W-1:0] b);
      int gap;
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_opcode  <= op;
      req_rx_byte <= b;
      do @(posedge clock); while (!req_ready);
      predict_card_item(op, b);
      items_sent++;
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_item(clhx_pkg::OP_BYTE, s[i]);
   endtask

   // Stops offering items and waits until the block has nothing left to send.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (id_chars_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   // Writes the timeout register while the block is idle, then reads it back.
   task automatic write_line_timeout(input logic [clhx_pkg::TIMEOUT_W-1:0] value);
      logic [clhx_pkg::CSR_DATA_W-1:0] got;
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= TIMEOUT_ADDR;
      csr_pwdata  <= clhx_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      line_timeout_q = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got[clhx_pkg::TIMEOUT_W-1:0] !== value) begin
         $error("line_timeout_ticks: expected %h, got %h", value,
                got[clhx_pkg::TIMEOUT_W-1:0]);
         err_count++;
      end
   endtask

   // Sends one reader line with random content and a random way of ending it.
   task automatic send_card_line();
      string hex_set;
      int    kind;
      int    len;
      int    pick;
      logic [clhx_pkg::BYTE_W-1:0] c;
      hex_set = "0123456789abcdefABCDEF";
      kind    = $urandom_range(9);
      len     = ($urandom_range(7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      for (int i = 0; i < len; i++) begin
         unique case (kind)
            6, 7: begin
               c = hex_set[$urandom_range(hex_set.len() - 1)];
            end
            8: begin
               c = clhx_pkg::BYTE_W'($urandom_range(255));
            end
            9: begin
               c = clhx_pkg::BYTE_W'($urandom_range(8'h67, 8'h7A));
            end
            default: begin
               c = clhx_pkg::ASCII_0 + clhx_pkg::BYTE_W'($urandom_range(9));
            end
         endcase
         // Ticks inside the line move the timeout along.
         if ($urandom_range(5) == 0) begin
            send_item(clhx_pkg::OP_TICK, clhx_pkg::BYTE_W'($urandom_range(255)));
         end
         send_item(clhx_pkg::OP_BYTE, c);
      end
      pick = $urandom_range(9);
      if (pick <= 3 || (pick >= 7 && line_timeout_q > 12)) begin
         send_item(clhx_pkg::OP_BYTE, clhx_pkg::ASCII_CR);
      end else if (pick <= 6) begin
         send_item(clhx_pkg::OP_BYTE, clhx_pkg::ASCII_LF);
      end else begin
         repeat (int'(line_timeout_q) + 1) begin
            send_item(clhx_pkg::OP_TICK, clhx_pkg::BYTE_W'($urandom_range(255)));
         end
      end
      // Stray items between lines.
      if ($urandom_range(7) == 0) begin
         repeat ($urandom_range(1, 4)) begin
            send_item(1'($urandom_range(1)), clhx_pkg::BYTE_W'($urandom_range(255)));
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Tests.
   // ------------------------------------------------------------------

   // Short lines ended by CR and by LF, the byte extremes and the idle cases.
   task automatic test_directed_lines();
      idle_pct  = 0;
      stall_pct = 0;
      send_item(clhx_pkg::OP_BYTE, clhx_pkg::ASCII_LF);
      send_text("12\r");
      send_text("0\r");
      send_item(clhx_pkg::OP_BYTE, 8'h00);
      send_item(clhx_pkg::OP_BYTE, 8'hFF);
      send_item(clhx_pkg::OP_BYTE, clhx_pkg::ASCII_9);
      send_item(clhx_pkg::OP_BYTE, clhx_pkg::ASCII_LF);
      send_text("Zf\r");
      send_text("aF\n");
      send_text("g-\r");
      send_item(clhx_pkg::OP_TICK, 8'hA5);
      wait_drained();
   endtask

   // Lines ended by ticks at the smallest and a small timeout, and a line that
   // the largest timeout keeps open until its CR.
   task automatic test_line_timeout();
      idle_pct  = 0;
      stall_pct = 0;
      write_line_timeout('0);
      send_text("4");
      send_item(clhx_pkg::OP_TICK, 8'h5A);
      write_line_timeout(16'd3);
      send_text("1b");
      repeat (4) send_item(clhx_pkg::OP_TICK, 8'h00);
      // Overlong line: dropped characters must not restart the timeout.
      send_text("123456789012345678901234567890123456789");
      repeat (4) send_item(clhx_pkg::OP_TICK, 8'hFF);
      write_line_timeout('1);
      send_text("5");
      repeat (8) send_item(clhx_pkg::OP_TICK, clhx_pkg::BYTE_W'($urandom_range(255)));
      send_item(clhx_pkg::OP_BYTE, clhx_pkg::ASCII_CR);
      wait_drained();
   endtask

   // Random lines under each idling pattern, with a new timeout per phase.
   task automatic test_random_lines();
      int idle_tab [4];
      int stall_tab [4];
      int stop_at;
      idle_tab  = '{0, 62, 0, 6};
      stall_tab = '{0, 0, 62, 6};
      for (int p = 0; p < 4; p++) begin
         write_line_timeout(clhx_pkg::TIMEOUT_W'($urandom_range(0, 8)));
         idle_pct  = idle_tab[p];
         stall_pct = stall_tab[p];
         stop_at   = items_sent + PHASE_ITEMS;
         while (items_sent < stop_at) send_card_line();
         wait_drained();
      end
   endtask

   // The receiver holds off while long lines keep coming, so the block fills up.
   task automatic test_backpressure();
      write_line_timeout(clhx_pkg::TIMEOUT_RESET);
      idle_pct  = 0;
      stall_pct = 0;
      hold_ask  = HOLD_CYC;
      send_text("18446744073709551615\r");
      send_text("99999999999999999999999\n");
      send_text("0123456789abcdefABCDEF0123456789\r");
      wait_drained();
      idle_pct  = 6;
      stall_pct = 6;
      repeat (6) send_card_line();
      wait_drained();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_lines();
      test_line_timeout();
      test_random_lines();
      test_backpressure();
      wait_drained();
      if (id_chars_q.size() != 0) begin
         $error("%0d identifier characters never arrived", id_chars_q.size());
         err_count++;
      end
      $display("Sent %0d items: directed lines, tick timeouts, four idling phases, backpressure.",
               items_sent);
      $display("Checked %0d characters in %0d identifiers, %0d mismatches.",
               chars_checked, ids_checked, err_count);
      if (err_count == 0) begin
         $display("** card_id_line_to_hex: PASSED **");
      end else begin
         $display("** card_id_line_to_hex: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
src/clhx_pkg.sv
src/clhx_ram.sv
src/clhx_front.sv
src/clhx_back.sv
src/card_id_line_to_hex.sv
src/clhx_checker.sv
sim/tb_card_id_line_to_hex.sv
